### hdl/nptf_pkg.sv
// ----------------------------------------------------------------------------
// nptf_pkg
// Shared types and sizing constants for the tangent-frame normal perturbation
// pipeline.
// ----------------------------------------------------------------------------
package nptf_pkg;

    // External component format: signed Q2.14
    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 14;

    // Vectors entering a normalise unit are sign extended to this width
    localparam int NV_W  = 34;
    localparam int MAG_W = NV_W - 1;      // magnitude of such a component
    localparam int POS_W = 6;             // MSB position of a magnitude
    localparam int SH_W  = 5;             // normalising shift amount
    localparam int NORM_TOP = 29;         // largest magnitude lands in [2^29, 2^30)
    localparam int NM_W  = NORM_TOP + 1;  // normalised magnitude
    localparam int SQR_W = 2 * NM_W;      // one square
    localparam int SQ_W  = SQR_W + 2;     // sum of three squares

    // Integer square root, one result bit per stage
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQ_RW    = SQ_W + 1;
    localparam int LEN_W    = SQ_STEPS;   // root of the sum reaches 2^30 and above

    // Rounded divide, one quotient bit per stage
    localparam int DEN_W    = LEN_W + 1;
    localparam int Q_W      = FRAC_BITS + 1;
    localparam int DV_STEPS = Q_W;
    localparam int DV_W     = NM_W + FRAC_BITS + 2;

    // Products of two components
    localparam int PROD_W = 2 * COMP_W;

    // Up-vector choice: 100 * n.z against 99 * 2^FRAC_BITS
    localparam int UP_W   = COMP_W + 7;
    localparam int UP_MUL = 100;
    localparam int UP_THR = 99 * (1 << FRAC_BITS);

    typedef logic [2:0][COMP_W-1:0] t_vec;
    typedef logic [2:0][NV_W-1:0]   t_nvec;

    // Data that rides alongside a normalise unit
    typedef struct packed {
        t_vec n;
        t_vec p;
        t_vec pv;
        logic zero;
    } t_side;

    typedef struct packed {
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic signed [COMP_W-1:0] pert_x;
        logic signed [COMP_W-1:0] pert_y;
        logic signed [COMP_W-1:0] pert_z;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_x;
        logic signed [COMP_W-1:0] out_y;
        logic signed [COMP_W-1:0] out_z;
        logic                     zero_length;
    } t_out;

endpackage

### hdl/normal_perturb_tangent_frame_top.sv
// Throughput: one transaction per cycle unless stalled; each of the three normalise
// units is fully pipelined (31 square-root and 15 divide stages set most of the depth).
// Stall from downstream freezes the whole pipeline; no transaction is lost or repeated.
// Reset (i_rst_n low, synchronous) clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// normal_perturb_tangent_frame_top
// Tangent-space normal perturbation in Q2.14: builds the tangent frame from
// the normal, mixes in the perturbation and returns the unit result.
// ----------------------------------------------------------------------------
module normal_perturb_tangent_frame_top
    import nptf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    // Output register valid, declared here as the advance depends on it.
    logic r_out_v;

    // Global advance: everything moves unless a finished result is held up.
    logic en;
    assign en      = !(r_out_v && i_stall);
    assign o_stall = r_out_v && i_stall;

    // ---- stage A: choose the up vector and form a = up x n -----------------
    // up = (0,0,-1) normally, (1,0,0) when |n.z| > 0.99 (tested as 100*n.z).
    logic signed [UP_W-1:0] n_nz100;
    logic                   n_steep;
    t_nvec                  n_a;
    t_side                  n_side_a;
    logic                   r_a_v;
    t_nvec                  r_a;
    t_side                  r_side_a;

    always_comb begin
        n_nz100 = UP_W'(i_data.normal_z) * UP_W'(UP_MUL);
        n_steep = (n_nz100 > UP_W'(UP_THR)) || (n_nz100 < -UP_W'(UP_THR));
        if (n_steep) begin
            n_a[0] = '0;
            n_a[1] = -NV_W'(i_data.normal_z);
            n_a[2] = NV_W'(i_data.normal_y);
        end else begin
            n_a[0] = NV_W'(i_data.normal_y);
            n_a[1] = -NV_W'(i_data.normal_x);
            n_a[2] = '0;
        end
        n_side_a.n    = {i_data.normal_z, i_data.normal_y, i_data.normal_x};
        n_side_a.p    = {i_data.pert_z, i_data.pert_y, i_data.pert_x};
        n_side_a.pv   = '0;
        n_side_a.zero = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_v <= 1'b0;
        else if (en) r_a_v <= i_valid;
        if (en) begin
            r_a      <= n_a;
            r_side_a <= n_side_a;
        end
    end

    // ---- pv = normalise(a) --------------------------------------------------
    logic  pv_v, pv_zero;
    t_vec  pv_unit;
    t_side pv_side_o, pv_side;

    nptf_norm u_norm_pv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_a_v),
        .i_vec   (r_a),
        .i_side  (r_side_a),
        .o_valid (pv_v),
        .o_unit  (pv_unit),
        .o_zero  (pv_zero),
        .o_side  (pv_side_o)
    );

    always_comb begin
        pv_side      = pv_side_o;
        pv_side.pv   = pv_unit;
        pv_side.zero = pv_zero;
    end

    // ---- b = n x pv ----------------------------------------------------------
    logic  b_v;
    t_nvec b_vec;
    t_side b_side;

    nptf_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pv_v),
        .i_side  (pv_side),
        .o_valid (b_v),
        .o_vec   (b_vec),
        .o_side  (b_side)
    );

    // ---- pu = normalise(b) --------------------------------------------------
    logic  pu_v, pu_zero;
    t_vec  pu_unit;
    t_side pu_side_o, pu_side;

    nptf_norm u_norm_pu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (b_v),
        .i_vec   (b_vec),
        .i_side  (b_side),
        .o_valid (pu_v),
        .o_unit  (pu_unit),
        .o_zero  (pu_zero),
        .o_side  (pu_side_o)
    );

    always_comb begin
        pu_side      = pu_side_o;
        pu_side.zero = pu_side_o.zero | pu_zero;
    end

    // ---- o = n + pu*px + pv*py + n*pz ---------------------------------------
    logic  o_sum_v;
    t_nvec o_sum;
    t_side o_sum_side;

    nptf_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pu_v),
        .i_pu    (pu_unit),
        .i_side  (pu_side),
        .o_valid (o_sum_v),
        .o_vec   (o_sum),
        .o_side  (o_sum_side)
    );

    // ---- r = normalise(o) ---------------------------------------------------
    logic  r_v, r_zero;
    t_vec  r_unit;
    t_side r_side;

    nptf_norm u_norm_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (o_sum_v),
        .i_vec   (o_sum),
        .i_side  (o_sum_side),
        .o_valid (r_v),
        .o_unit  (r_unit),
        .o_zero  (r_zero),
        .o_side  (r_side)
    );

    // ---- output register ----------------------------------------------------
    // Unit components never exceed 2^14 in magnitude, so they fit Q2.14 with no
    // clamp; any zero-length vector on the way forces zeros and the flag.
    t_out r_out;
    t_out n_out;
    logic n_zero;

    always_comb begin
        n_zero             = r_side.zero | r_zero;
        n_out.out_x        = n_zero ? '0 : r_unit[0];
        n_out.out_y        = n_zero ? '0 : r_unit[1];
        n_out.out_z        = n_zero ? '0 : r_unit[2];
        n_out.zero_length  = n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else if (en) r_out_v <= r_v;
        if (en) r_out <= n_out;
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

### hdl/nptf_norm.sv
// ----------------------------------------------------------------------------
// nptf_norm
// Pipelined fixed-point vector normalise: block scaling, squares, bit-serial
// square root and three rounded divides, carrying side data along.
// ----------------------------------------------------------------------------
module nptf_norm
    import nptf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_nvec i_vec,
    input  t_side i_side,
    output logic  o_valid,
    output t_vec  o_unit,
    output logic  o_zero,
    output t_side o_side
);

    // stage 1: magnitudes
    logic [MAG_W-1:0] n1_mag [3];
    logic [NV_W-1:0]  n1_negv [3];
    logic [2:0]       n1_neg;
    logic             r1_v;
    logic [MAG_W-1:0] r1_mag [3];
    logic [2:0]       r1_neg;
    t_side            r1_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_neg[i]  = i_vec[i][NV_W-1];
            n1_negv[i] = -i_vec[i];
            n1_mag[i]  = n1_neg[i] ? n1_negv[i][MAG_W-1:0] : i_vec[i][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (i_en) r1_v <= i_valid;
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_neg  <= n1_neg;
            r1_side <= i_side;
        end
    end

    // stage 2: largest magnitude
    logic [MAG_W-1:0] n2_top, n2_t01;
    logic             r2_v;
    logic [MAG_W-1:0] r2_top;
    logic [MAG_W-1:0] r2_mag [3];
    logic [2:0]       r2_neg;
    t_side            r2_side;

    always_comb begin
        n2_t01 = (r1_mag[0] > r1_mag[1]) ? r1_mag[0] : r1_mag[1];
        n2_top = (n2_t01 > r1_mag[2]) ? n2_t01 : r1_mag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (i_en) r2_v <= r1_v;
        if (i_en) begin
            r2_top  <= n2_top;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_side <= r1_side;
        end
    end

    // stage 3: shift amount from the MSB position
    logic [POS_W-1:0] n3_pos;
    logic             n3_shr;
    logic [SH_W-1:0]  n3_sh;
    logic             r3_v, r3_shr, r3_zero;
    logic [SH_W-1:0]  r3_sh;
    logic [MAG_W-1:0] r3_mag [3];
    logic [2:0]       r3_neg;
    t_side            r3_side;

    always_comb begin
        n3_pos = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r2_top[b]) n3_pos = POS_W'(b);
        end
        n3_shr = (n3_pos > POS_W'(NORM_TOP));
        n3_sh  = n3_shr ? SH_W'(n3_pos - POS_W'(NORM_TOP))
                        : SH_W'(POS_W'(NORM_TOP) - n3_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (i_en) r3_v <= r2_v;
        if (i_en) begin
            r3_shr  <= n3_shr;
            r3_sh   <= n3_sh;
            r3_zero <= (r2_top == '0);
            r3_mag  <= r2_mag;
            r3_neg  <= r2_neg;
            r3_side <= r2_side;
        end
    end

    // stage 4: common shift (right shift truncates)
    logic [NM_W+MAG_W-1:0] n4_wide [3];
    logic [MAG_W-1:0]      n4_rsh [3];
    logic [NM_W-1:0]       n4_m [3];
    logic                  r4_v, r4_zero;
    logic [NM_W-1:0]       r4_m [3];
    logic [2:0]            r4_neg;
    t_side                 r4_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_wide[i] = {NM_W'(0), r3_mag[i]} << r3_sh;
            n4_rsh[i]  = r3_mag[i] >> r3_sh;
            n4_m[i]    = r3_shr ? n4_rsh[i][NM_W-1:0] : n4_wide[i][NM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (i_en) r4_v <= r3_v;
        if (i_en) begin
            r4_m    <= n4_m;
            r4_zero <= r3_zero;
            r4_neg  <= r3_neg;
            r4_side <= r3_side;
        end
    end

    // stage 5: squares
    logic [SQR_W-1:0] n5_sq [3];
    logic             r5_v, r5_zero;
    logic [SQR_W-1:0] r5_sq [3];
    logic [NM_W-1:0]  r5_m [3];
    logic [2:0]       r5_neg;
    t_side            r5_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_sq[i] = SQR_W'(r4_m[i]) * SQR_W'(r4_m[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (i_en) r5_v <= r4_v;
        if (i_en) begin
            r5_sq   <= n5_sq;
            r5_m    <= r4_m;
            r5_zero <= r4_zero;
            r5_neg  <= r4_neg;
            r5_side <= r4_side;
        end
    end

    // stage 6 and square root stages; index 0 holds the sum of squares
    logic             r_sq_v    [0:SQ_STEPS];
    logic [SQ_W-1:0]  r_sq_x    [0:SQ_STEPS];
    logic [SQ_RW-1:0] r_sq_res  [0:SQ_STEPS];
    logic [NM_W-1:0]  r_sq_m    [0:SQ_STEPS][3];
    logic [2:0]       r_sq_neg  [0:SQ_STEPS];
    logic             r_sq_zero [0:SQ_STEPS];
    t_side            r_sq_side [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_v[0] <= 1'b0;
        else if (i_en) r_sq_v[0] <= r5_v;
        if (i_en) begin
            r_sq_x[0]    <= SQ_W'(r5_sq[0]) + SQ_W'(r5_sq[1]) + SQ_W'(r5_sq[2]);
            r_sq_res[0]  <= '0;
            r_sq_m[0]    <= r5_m;
            r_sq_neg[0]  <= r5_neg;
            r_sq_zero[0] <= r5_zero;
            r_sq_side[0] <= r5_side;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [SQ_RW-1:0] n_bit, n_trial, n_res;
        logic [SQ_W-1:0]  n_x;
        logic             n_take;

        always_comb begin
            n_bit   = SQ_RW'(1) << (2 * (SQ_STEPS - 1 - k));
            n_trial = r_sq_res[k] + n_bit;
            n_take  = (SQ_RW'(r_sq_x[k]) >= n_trial);
            n_x     = n_take ? (r_sq_x[k] - n_trial[SQ_W-1:0]) : r_sq_x[k];
            n_res   = n_take ? ((r_sq_res[k] >> 1) + n_bit) : (r_sq_res[k] >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[k+1] <= 1'b0;
            else if (i_en) r_sq_v[k+1] <= r_sq_v[k];
            if (i_en) begin
                r_sq_x[k+1]    <= n_x;
                r_sq_res[k+1]  <= n_res;
                r_sq_m[k+1]    <= r_sq_m[k];
                r_sq_neg[k+1]  <= r_sq_neg[k];
                r_sq_zero[k+1] <= r_sq_zero[k];
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // divide set-up and stages: q = (m * 2^(F+1) + L) / (2L)
    logic             r_dv_v    [0:DV_STEPS];
    logic [DV_W-1:0]  r_dv_rem  [0:DV_STEPS][3];
    logic [DEN_W-1:0] r_dv_den  [0:DV_STEPS];
    logic [Q_W-1:0]   r_dv_q    [0:DV_STEPS][3];
    logic [2:0]       r_dv_neg  [0:DV_STEPS];
    logic             r_dv_zero [0:DV_STEPS];
    t_side            r_dv_side [0:DV_STEPS];

    logic [LEN_W-1:0] n_len;
    logic [DV_W-1:0]  n_num [3];

    always_comb begin
        n_len = r_sq_res[SQ_STEPS][LEN_W-1:0];
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (DV_W'(r_sq_m[SQ_STEPS][i]) << (FRAC_BITS + 1)) + DV_W'(n_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_v[0] <= 1'b0;
        else if (i_en) r_dv_v[0] <= r_sq_v[SQ_STEPS];
        if (i_en) begin
            r_dv_rem[0]  <= n_num;
            r_dv_den[0]  <= {n_len, 1'b0};
            for (int i = 0; i < 3; i++) r_dv_q[0][i] <= '0;
            r_dv_neg[0]  <= r_sq_neg[SQ_STEPS];
            r_dv_zero[0] <= r_sq_zero[SQ_STEPS];
            r_dv_side[0] <= r_sq_side[SQ_STEPS];
        end
    end

    for (genvar j = 0; j < DV_STEPS; j++) begin : g_dv
        logic [DV_W-1:0] n_sub;
        logic [DV_W-1:0] n_rem [3];
        logic [Q_W-1:0]  n_q   [3];

        always_comb begin
            n_sub = DV_W'(r_dv_den[j]) << (DV_STEPS - 1 - j);
            for (int i = 0; i < 3; i++) begin
                n_rem[i] = r_dv_rem[j][i];
                n_q[i]   = r_dv_q[j][i];
                if (r_dv_rem[j][i] >= n_sub) begin
                    n_rem[i] = r_dv_rem[j][i] - n_sub;
                    n_q[i]   = r_dv_q[j][i] | (Q_W'(1) << (DV_STEPS - 1 - j));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv_v[j+1] <= 1'b0;
            else if (i_en) r_dv_v[j+1] <= r_dv_v[j];
            if (i_en) begin
                r_dv_rem[j+1]  <= n_rem;
                r_dv_q[j+1]    <= n_q;
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_neg[j+1]  <= r_dv_neg[j];
                r_dv_zero[j+1] <= r_dv_zero[j];
                r_dv_side[j+1] <= r_dv_side[j];
            end
        end
    end

    // output stage: restore signs; a zero vector gives zeros
    logic [COMP_W-1:0] n_qe [3];
    t_vec              n_unit;
    logic              r_o_v, r_o_zero;
    t_vec              r_o_unit;
    t_side             r_o_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_qe[i]   = COMP_W'(r_dv_q[DV_STEPS][i]);
            n_unit[i] = r_dv_zero[DV_STEPS] ? '0
                      : (r_dv_neg[DV_STEPS][i] ? -n_qe[i] : n_qe[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_v <= 1'b0;
        else if (i_en) r_o_v <= r_dv_v[DV_STEPS];
        if (i_en) begin
            r_o_unit <= n_unit;
            r_o_zero <= r_dv_zero[DV_STEPS];
            r_o_side <= r_dv_side[DV_STEPS];
        end
    end

    assign o_valid = r_o_v;
    assign o_unit  = r_o_unit;
    assign o_zero  = r_o_zero;
    assign o_side  = r_o_side;

endmodule

### hdl/nptf_cross.sv
// ----------------------------------------------------------------------------
// nptf_cross
// Two-stage cross product b = n x pv: six products, then differences.
// ----------------------------------------------------------------------------
module nptf_cross
    import nptf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_side i_side,
    output logic  o_valid,
    output t_nvec o_vec,
    output t_side o_side
);

    logic signed [PROD_W-1:0] n_pr [6];
    logic signed [PROD_W-1:0] r_pr [6];
    logic                     r_v1, r_v2;
    t_side                    r_side1, r_side2;
    t_nvec                    n_b, r_b;

    always_comb begin
        n_pr[0] = $signed(i_side.n[1]) * $signed(i_side.pv[2]);
        n_pr[1] = $signed(i_side.n[2]) * $signed(i_side.pv[1]);
        n_pr[2] = $signed(i_side.n[2]) * $signed(i_side.pv[0]);
        n_pr[3] = $signed(i_side.n[0]) * $signed(i_side.pv[2]);
        n_pr[4] = $signed(i_side.n[0]) * $signed(i_side.pv[1]);
        n_pr[5] = $signed(i_side.n[1]) * $signed(i_side.pv[0]);
        for (int i = 0; i < 3; i++) begin
            n_b[i] = NV_W'(r_pr[2*i]) - NV_W'(r_pr[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_pr    <= n_pr;
            r_side1 <= i_side;
            r_b     <= n_b;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_b;
    assign o_side  = r_side2;

endmodule

### hdl/nptf_blend.sv
// ----------------------------------------------------------------------------
// nptf_blend
// Two-stage weighted sum o = n + pu*px + pv*py + n*pz at 2*F fraction bits.
// ----------------------------------------------------------------------------
module nptf_blend
    import nptf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_vec  i_pu,
    input  t_side i_side,
    output logic  o_valid,
    output t_nvec o_vec,
    output t_side o_side
);

    logic signed [PROD_W-1:0] n_t [3][4];
    logic signed [PROD_W-1:0] r_t [3][4];
    logic                     r_v1, r_v2;
    t_side                    r_side1, r_side2;
    t_nvec                    n_o, r_o;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i][0] = PROD_W'($signed(i_side.n[i])) <<< FRAC_BITS;
            n_t[i][1] = $signed(i_pu[i]) * $signed(i_side.p[0]);
            n_t[i][2] = $signed(i_side.pv[i]) * $signed(i_side.p[1]);
            n_t[i][3] = $signed(i_side.n[i]) * $signed(i_side.p[2]);
            n_o[i]    = NV_W'(r_t[i][0]) + NV_W'(r_t[i][1])
                      + NV_W'(r_t[i][2]) + NV_W'(r_t[i][3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_t     <= n_t;
            r_side1 <= i_side;
            r_o     <= n_o;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_vec   = r_o;
    assign o_side  = r_side2;

endmodule

### hdl/nptf_checker.sv
// ----------------------------------------------------------------------------
// nptf_checker
// Port-level assertions for the tangent-frame perturbation block.
// ----------------------------------------------------------------------------
module nptf_checker
    import nptf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output transaction changed");

    a_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_length) |->
            (o_data.out_x == '0 && o_data.out_y == '0 && o_data.out_z == '0))
        else $error("zero-length result carries non-zero components");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.zero_length) |->
            (o_data.out_x <= 16'sd16384 && o_data.out_x >= -16'sd16384 &&
             o_data.out_y <= 16'sd16384 && o_data.out_y >= -16'sd16384 &&
             o_data.out_z <= 16'sd16384 && o_data.out_z >= -16'sd16384))
        else $error("unit component beyond 1.0");

endmodule

bind normal_perturb_tangent_frame_top nptf_checker u_nptf_checker (.*);
